FILE: rtl/tals_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis line stepper: shared definitions
// Default widths, register indexes, item kinds, axis codes and the result
// item layout used by the stepper and its planning logic.
// ----------------------------------------------------------------------------
package tals_pkg;

    // Default widths for position and step period.
    localparam int POS_BITS_DEF    = 24;
    localparam int PERIOD_BITS_DEF = 20;

    // Step period after reset, in microsecond ticks.
    localparam int STEP_PERIOD_RST = 1000;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT_Y    = 1'd1;

    // Input item kinds.
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Axis codes.
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // Outcome of planning a move.
    typedef struct packed {
        t_axis      major_axis;
        logic [2:0] dir_bits;
        logic       zero_len;
    } t_plan;

    // One result item.
    typedef struct packed {
        logic step_x;
        logic step_y;
        logic step_z;
        logic dir_x;
        logic dir_y;
        logic dir_z;
        logic busy_res;
        logic move_done;
        logic rejected;
    } t_result;

    // One-hot step mask of an axis: bit 0 x, bit 1 y, bit 2 z.
    function automatic logic [2:0] axis_mask(input t_axis axis);
        logic [2:0] mask;
        case (axis)
            AXIS_X:  mask = 3'b001;
            AXIS_Y:  mask = 3'b010;
            default: mask = 3'b100;
        endcase
        return mask;
    endfunction

endpackage

FILE: rtl/tals_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis line stepper: channel interfaces
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------

// Command channel: a move with an absolute target, or one microsecond tick.
interface tals_cmd_if #(
    parameter int POS_BITS = tals_pkg::POS_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic signed [POS_BITS-1:0] target_z;

    modport source (output valid, kind, target_x, target_y, target_z, input ready);
    modport sink   (input valid, kind, target_x, target_y, target_z, output ready);
endinterface

// Result channel: step pulses, direction lines and move status.
interface tals_res_if ();
    logic valid;
    logic ready;
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic busy_res;
    logic move_done;
    logic rejected;

    modport source (output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                    busy_res, move_done, rejected, input ready);
    modport sink   (input valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                    busy_res, move_done, rejected, output ready);
endinterface

FILE: rtl/three_axis_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis line stepper
// Step and direction generator for three axes drawing straight moves with
// Bresenham interpolation, one command or microsecond tick item at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Carries
//  i_cmd     in   valid / ready      kind, target_x, target_y, target_z
//  o_res     out  valid / ready      step_x/y/z, dir_x/y/z, busy_res,
//                                    move_done, rejected
//  i_cfg_*   in   write enable only  register index, write data
//
//  One item per clock is sustained while o_res is ready: every item passes an
//  input register and then a result register, which drives o_res.
//  The per-item work is at most one step of the Bresenham accumulators or one move plan.
//  i_rst_n is synchronous; reset gives an idle block at position zero.
//  A result waiting on o_res holds the input register, and i_cmd.ready falls
//  only when both registers are full.
// ----------------------------------------------------------------------------
module three_axis_line_stepper #(
    parameter int POS_BITS    = tals_pkg::POS_BITS_DEF,
    parameter int PERIOD_BITS = tals_pkg::PERIOD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tals_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [PERIOD_BITS-1:0]              i_cfg_data,
    tals_cmd_if.sink                            i_cmd,
    tals_res_if.source                          o_res
);

    // Configuration registers.
    logic [PERIOD_BITS-1:0] r_step_period;
    logic                   r_invert_y;

    // Input register.
    logic                       r_in_valid;
    logic                       r_in_kind;
    logic signed [POS_BITS-1:0] r_in_tx;
    logic signed [POS_BITS-1:0] r_in_ty;
    logic signed [POS_BITS-1:0] r_in_tz;

    // Motion state and its next values.
    logic [POS_BITS-1:0]    r_pos_x,  n_pos_x;
    logic [POS_BITS-1:0]    r_pos_y,  n_pos_y;
    logic [POS_BITS-1:0]    r_pos_z,  n_pos_z;
    logic [POS_BITS:0]      r_mag_x,  n_mag_x;
    logic [POS_BITS:0]      r_mag_y,  n_mag_y;
    logic [POS_BITS:0]      r_mag_z,  n_mag_z;
    tals_pkg::t_axis        r_major_axis, n_major_axis;
    logic [POS_BITS+1:0]    r_err_first,  n_err_first;
    logic [POS_BITS+1:0]    r_err_second, n_err_second;
    logic [POS_BITS:0]      r_steps_left, n_steps_left;
    logic [2:0]             r_dir_bits,   n_dir_bits;
    logic [PERIOD_BITS-1:0] r_wait_count, n_wait_count;
    logic                   r_moving,     n_moving;

    // Result register.
    logic              r_out_valid;
    tals_pkg::t_result r_out, n_out;

    // Planner outputs.
    logic [POS_BITS:0] w_mag_x;
    logic [POS_BITS:0] w_mag_y;
    logic [POS_BITS:0] w_mag_z;
    logic [POS_BITS:0] w_plan_major;
    tals_pkg::t_plan   w_plan;

    // Per-tick working values.
    logic                   w_out_free;
    logic                   w_advance;
    logic [PERIOD_BITS-1:0] w_period;
    logic [PERIOD_BITS-1:0] w_wait_dec;
    logic [POS_BITS:0]      w_major;
    logic [POS_BITS:0]      w_m1;
    logic [POS_BITS:0]      w_m2;
    tals_pkg::t_axis        w_a1;
    tals_pkg::t_axis        w_a2;
    logic [POS_BITS+1:0]    w_sum1;
    logic [POS_BITS+1:0]    w_sum2;
    logic                   w_hit1;
    logic                   w_hit2;
    logic [2:0]             w_steps;
    logic                   w_done;
    logic                   w_rej;

    // Handshake: the item in the input register moves on when the result
    // register is empty or being emptied.
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_cmd.ready = !r_in_valid || w_advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= PERIOD_BITS'(tals_pkg::STEP_PERIOD_RST);
            r_invert_y    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tals_pkg::CFG_STEP_PERIOD: r_step_period <= i_cfg_data;
                tals_pkg::CFG_INVERT_Y:    r_invert_y    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_kind <= i_cmd.kind;
            r_in_tx   <= i_cmd.target_x;
            r_in_ty   <= i_cmd.target_y;
            r_in_tz   <= i_cmd.target_z;
        end
    end

    // Move planning from the buffered target and the tracked position.
    tals_move_plan #(
        .POS_BITS (POS_BITS)
    ) u_plan (
        .i_target_x (r_in_tx),
        .i_target_y (r_in_ty),
        .i_target_z (r_in_tz),
        .i_pos_x    (r_pos_x),
        .i_pos_y    (r_pos_y),
        .i_pos_z    (r_pos_z),
        .o_mag_x    (w_mag_x),
        .o_mag_y    (w_mag_y),
        .o_mag_z    (w_mag_z),
        .o_major    (w_plan_major),
        .o_plan     (w_plan)
    );

    // A zero period behaves as one tick.
    assign w_period   = (r_step_period == '0) ? PERIOD_BITS'(1) : r_step_period;
    assign w_wait_dec = (r_wait_count != '0) ? r_wait_count - PERIOD_BITS'(1) : '0;

    // Major length and the two minor axes, the lower-lettered one first.
    always_comb begin
        case (r_major_axis)
            tals_pkg::AXIS_X: begin
                w_major = r_mag_x;
                w_m1    = r_mag_y;
                w_a1    = tals_pkg::AXIS_Y;
                w_m2    = r_mag_z;
                w_a2    = tals_pkg::AXIS_Z;
            end
            tals_pkg::AXIS_Y: begin
                w_major = r_mag_y;
                w_m1    = r_mag_x;
                w_a1    = tals_pkg::AXIS_X;
                w_m2    = r_mag_z;
                w_a2    = tals_pkg::AXIS_Z;
            end
            default: begin
                w_major = r_mag_z;
                w_m1    = r_mag_x;
                w_a1    = tals_pkg::AXIS_X;
                w_m2    = r_mag_y;
                w_a2    = tals_pkg::AXIS_Y;
            end
        endcase
    end

    // Error accumulators: each stays below the major length, so the sum stays
    // below twice that and one subtract brings it back.
    assign w_sum1 = r_err_first  + {1'b0, w_m1};
    assign w_sum2 = r_err_second + {1'b0, w_m2};
    assign w_hit1 = (w_sum1 >= {1'b0, w_major});
    assign w_hit2 = (w_sum2 >= {1'b0, w_major});

    // Next state for one item.
    always_comb begin
        n_mag_x      = r_mag_x;
        n_mag_y      = r_mag_y;
        n_mag_z      = r_mag_z;
        n_major_axis = r_major_axis;
        n_err_first  = r_err_first;
        n_err_second = r_err_second;
        n_steps_left = r_steps_left;
        n_dir_bits   = r_dir_bits;
        n_wait_count = r_wait_count;
        n_moving     = r_moving;
        w_steps      = 3'b000;
        w_done       = 1'b0;
        w_rej        = 1'b0;

        if (r_in_kind == tals_pkg::KIND_MOVE) begin
            if (r_moving) begin
                w_rej = 1'b1;
            end else begin
                n_mag_x      = w_mag_x;
                n_mag_y      = w_mag_y;
                n_mag_z      = w_mag_z;
                n_major_axis = w_plan.major_axis;
                n_dir_bits   = w_plan.dir_bits;
                n_err_first  = {2'b00, w_plan_major[POS_BITS:1]};
                n_err_second = '0;
                n_steps_left = w_plan_major;
                n_wait_count = '0;
                w_done       = w_plan.zero_len;
                n_moving     = !w_plan.zero_len;
            end
        end else if (r_moving) begin
            n_wait_count = w_wait_dec;
            if (w_wait_dec == '0) begin
                if (r_steps_left == '0) begin
                    n_moving = 1'b0;
                    w_done   = 1'b1;
                end else begin
                    w_steps = tals_pkg::axis_mask(r_major_axis)
                            | (w_hit1 ? tals_pkg::axis_mask(w_a1) : 3'b000)
                            | (w_hit2 ? tals_pkg::axis_mask(w_a2) : 3'b000);
                    n_err_first  = w_hit1 ? w_sum1 - {1'b0, w_major} : w_sum1;
                    n_err_second = w_hit2 ? w_sum2 - {1'b0, w_major} : w_sum2;
                    n_steps_left = r_steps_left - 1'b1;
                    n_wait_count = w_period;
                end
            end
        end
    end

    // Position follows every step pulse in its axis direction.
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (w_steps[0]) begin
            n_pos_x = r_dir_bits[0] ? r_pos_x + 1'b1 : r_pos_x - 1'b1;
        end
        if (w_steps[1]) begin
            n_pos_y = r_dir_bits[1] ? r_pos_y + 1'b1 : r_pos_y - 1'b1;
        end
        if (w_steps[2]) begin
            n_pos_z = r_dir_bits[2] ? r_pos_z + 1'b1 : r_pos_z - 1'b1;
        end
    end

    // Result item contents.
    always_comb begin
        n_out.step_x    = w_steps[0];
        n_out.step_y    = w_steps[1];
        n_out.step_z    = w_steps[2];
        n_out.dir_x     = n_dir_bits[0];
        n_out.dir_y     = n_dir_bits[1] ^ r_invert_y;
        n_out.dir_z     = n_dir_bits[2];
        n_out.busy_res  = n_moving;
        n_out.move_done = w_done;
        n_out.rejected  = w_rej;
    end

    // Motion state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_pos_z      <= '0;
            r_mag_x      <= '0;
            r_mag_y      <= '0;
            r_mag_z      <= '0;
            r_major_axis <= tals_pkg::AXIS_X;
            r_err_first  <= '0;
            r_err_second <= '0;
            r_steps_left <= '0;
            r_dir_bits   <= '0;
            r_wait_count <= '0;
            r_moving     <= 1'b0;
        end else if (w_advance) begin
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_pos_z      <= n_pos_z;
            r_mag_x      <= n_mag_x;
            r_mag_y      <= n_mag_y;
            r_mag_z      <= n_mag_z;
            r_major_axis <= n_major_axis;
            r_err_first  <= n_err_first;
            r_err_second <= n_err_second;
            r_steps_left <= n_steps_left;
            r_dir_bits   <= n_dir_bits;
            r_wait_count <= n_wait_count;
            r_moving     <= n_moving;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // Result channel.
    assign o_res.valid     = r_out_valid;
    assign o_res.step_x    = r_out.step_x;
    assign o_res.step_y    = r_out.step_y;
    assign o_res.step_z    = r_out.step_z;
    assign o_res.dir_x     = r_out.dir_x;
    assign o_res.dir_y     = r_out.dir_y;
    assign o_res.dir_z     = r_out.dir_z;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.move_done = r_out.move_done;
    assign o_res.rejected  = r_out.rejected;

endmodule

FILE: rtl/tals_move_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis line stepper: move planner
// Takes the signed deltas from the tracked position to the target, their
// magnitudes and directions, and picks the major axis (x wins ties, then y).
// ----------------------------------------------------------------------------
module tals_move_plan #(
    parameter int POS_BITS = tals_pkg::POS_BITS_DEF
) (
    input  logic signed [POS_BITS-1:0] i_target_x,
    input  logic signed [POS_BITS-1:0] i_target_y,
    input  logic signed [POS_BITS-1:0] i_target_z,
    input  logic        [POS_BITS-1:0] i_pos_x,
    input  logic        [POS_BITS-1:0] i_pos_y,
    input  logic        [POS_BITS-1:0] i_pos_z,
    output logic        [POS_BITS:0]   o_mag_x,
    output logic        [POS_BITS:0]   o_mag_y,
    output logic        [POS_BITS:0]   o_mag_z,
    output logic        [POS_BITS:0]   o_major,
    output tals_pkg::t_plan            o_plan
);

    logic signed [POS_BITS:0] w_dx;
    logic signed [POS_BITS:0] w_dy;
    logic signed [POS_BITS:0] w_dz;

    // Deltas one bit wider than a position, so they never overflow.
    assign w_dx = signed'({i_target_x[POS_BITS-1], i_target_x})
                - signed'({i_pos_x[POS_BITS-1], i_pos_x});
    assign w_dy = signed'({i_target_y[POS_BITS-1], i_target_y})
                - signed'({i_pos_y[POS_BITS-1], i_pos_y});
    assign w_dz = signed'({i_target_z[POS_BITS-1], i_target_z})
                - signed'({i_pos_z[POS_BITS-1], i_pos_z});

    // Magnitudes; the largest is 2**POS_BITS - 1, which still fits unsigned.
    assign o_mag_x = w_dx[POS_BITS] ? unsigned'(-w_dx) : unsigned'(w_dx);
    assign o_mag_y = w_dy[POS_BITS] ? unsigned'(-w_dy) : unsigned'(w_dy);
    assign o_mag_z = w_dz[POS_BITS] ? unsigned'(-w_dz) : unsigned'(w_dz);

    // Major axis selection and directions; a zero delta counts as negative.
    always_comb begin
        o_plan.dir_bits = {(w_dz > 0), (w_dy > 0), (w_dx > 0)};
        if (o_mag_x >= o_mag_y && o_mag_x >= o_mag_z) begin
            o_plan.major_axis = tals_pkg::AXIS_X;
            o_major           = o_mag_x;
        end else if (o_mag_y >= o_mag_z) begin
            o_plan.major_axis = tals_pkg::AXIS_Y;
            o_major           = o_mag_y;
        end else begin
            o_plan.major_axis = tals_pkg::AXIS_Z;
            o_major           = o_mag_z;
        end
        o_plan.zero_len = (o_major == '0);
    end

endmodule
